>>> rtl/sgdmf_pkg.sv
// Shared types, constants and arithmetic helpers for the SGD factor update engine.
`default_nettype none
package sgdmf_pkg;
  localparam int K_FACTORS  = 16;
  localparam int USER_DEPTH = 1024;
  localparam int ITEM_DEPTH = 1024;
  localparam int KW   = (K_FACTORS > 1) ? $clog2(K_FACTORS) : 1;
  localparam int UAW  = (USER_DEPTH > 1) ? $clog2(USER_DEPTH) : 1;
  localparam int IAW  = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
  localparam int UMW  = UAW + KW;
  localparam int IMW  = IAW + KW;
  localparam int KCW  = $clog2(K_FACTORS + 1);
  localparam int ACCW = 32 + KCW + 1;

  localparam logic [15:0] STEP_RESET = 16'd655;
  localparam logic [15:0] REG_RESET  = 16'd1311;

  localparam logic [0:0] CFG_STEP = 1'b0;
  localparam logic [0:0] CFG_REG  = 1'b1;

  typedef enum logic [2:0] {
    KIND_TRAIN = 3'd0,
    KIND_WR_USER = 3'd1,
    KIND_WR_ITEM = 3'd2,
    KIND_RD_USER = 3'd3,
    KIND_RD_ITEM = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACCESS, ST_RDWAIT, ST_DOT, ST_ERR,
    ST_UPD_A, ST_UPD_B, ST_UPD_C, ST_UPD_D, ST_OUT
  } state_t;

  // Saturate a wide signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) return 16'sh7fff;
    else if (x < -64'sd32768) return 16'sh8000;
    else return x[15:0];
  endfunction
endpackage
`default_nettype wire

>>> rtl/sgd_matrix_factor_update_top.sv
// Top level of the SGD matrix factorization update engine.
// Requests are handled one at a time, and with a ready receiver the next request is taken the
// cycle after the previous result has been accepted. A factor write or an unused kind passes
// through the access and output states, and a factor read adds a read-wait state between them.
// A train request passes through an access state, one dot-product state per element and an
// error state. Then it passes through four states per element (read, form the update term,
// scale by the step size, write back), first for the user row and then again for the item
// row, and then through an output state. Each factor table sits in a synchronous RAM with
// one read port and one write port. A stalled receiver adds its stall cycles, because the
// result sits in an output register that blocks the input until it is taken. Unwritten
// elements read as arbitrary values. Configuration writes are accepted at any time and
// belong only between requests.
`default_nettype none
module sgd_matrix_factor_update_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: user_index[9:0], item_index[19:10], factor_index[23:20], value_in[39:24]
  input  wire logic [39:0] in_tdata,
  // tuser: kind[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: error_out[15:0], read_out[31:16]
  output logic [31:0]      out_tdata
);
  localparam int KW  = sgdmf_pkg::KW;
  localparam int UMW = sgdmf_pkg::UMW;
  localparam int IMW = sgdmf_pkg::IMW;

  sgdmf_pkg::state_t state_r, state_nxt;
  logic [15:0] step_r, regw_r;
  logic [2:0]  kind_r;
  logic [sgdmf_pkg::UAW-1:0] urow_r;
  logic [sgdmf_pkg::IAW-1:0] irow_r;
  logic [3:0]  fidx_r;
  logic signed [15:0] val_r;
  logic [KW:0] cnt_r, cnt_nxt;
  logic        phase_r, phase_nxt;        // 0: user row, 1: item row
  logic signed [sgdmf_pkg::ACCW-1:0] acc_r, acc_nxt;
  logic signed [15:0] err_r, err_nxt;
  logic signed [47:0] t_r, t_nxt;
  logic signed [15:0] y_r, y_nxt;
  logic [31:0] out_r, out_nxt;
  logic        outv_r, outv_nxt;
  logic signed [15:0] urd, ird;

  // table ports
  logic          u_we, i_we;
  logic [UMW-1:0] u_wa, u_ra;
  logic [IMW-1:0] i_wa, i_ra;
  logic [15:0]   u_wd, i_wd;
  logic [15:0]   urd_raw, ird_raw;

  sgdmf_ram #(.AW(UMW), .DW(16)) u_user (
    .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(urd_raw));
  sgdmf_ram #(.AW(IMW), .DW(16)) u_item (
    .clk(clk), .we(i_we), .waddr(i_wa), .wdata(i_wd), .raddr(i_ra), .rdata(ird_raw));
  assign urd = urd_raw;
  assign ird = ird_raw;

  wire logic fok = ({1'b0, fidx_r} < 5'(sgdmf_pkg::K_FACTORS));
  wire logic [KW-1:0] kidx = cnt_r[KW-1:0];
  wire logic [KW-1:0] fk = fidx_r[KW-1:0];
  wire logic last = (cnt_r == (KW+1)'(sgdmf_pkg::K_FACTORS - 1));

  assign in_tready = (state_r == sgdmf_pkg::ST_IDLE) && !outv_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = outv_r;
  assign out_tdata = out_r;

  // products for the element step, one element per step
  logic signed [31:0] prod_uv;
  logic signed [31:0] prod_ex;
  logic signed [32:0] prod_ry;
  logic signed [15:0] xsel, ysel;
  logic signed [64:0] prod_st;
  logic signed [64:0] dsum;
  logic signed [47:0] dval;
  assign xsel = phase_r ? urd : ird;
  assign ysel = phase_r ? ird : urd;
  assign prod_uv = urd * ird;
  assign prod_ex = err_r * xsel;
  assign prod_ry = $signed({1'b0, regw_r}) * ysel;
  assign prod_st = $signed({1'b0, step_r}) * t_r;
  assign dsum = prod_st + 65'sh80000000;
  assign dval = 48'(dsum >>> 32);

  // rounded error from accumulated dot product
  logic signed [sgdmf_pkg::ACCW+12:0] ediff;
  assign ediff = ((sgdmf_pkg::ACCW+13)'(val_r) <<< 12) - (sgdmf_pkg::ACCW+13)'(acc_r)
                 + (sgdmf_pkg::ACCW+13)'(2048);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sgdmf_pkg::STEP_RESET;
      regw_r <= sgdmf_pkg::REG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sgdmf_pkg::CFG_STEP: step_r <= cfg_data;
        sgdmf_pkg::CFG_REG:  regw_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture request; row indexes wrap at the power-of-two table depth
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      urow_r <= in_tdata[sgdmf_pkg::UAW-1:0];
      irow_r <= in_tdata[10 +: sgdmf_pkg::IAW];
      fidx_r <= in_tdata[23:20];
      val_r  <= in_tdata[39:24];
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgdmf_pkg::ST_IDLE;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
    end
    cnt_r <= cnt_nxt; phase_r <= phase_nxt; acc_r <= acc_nxt;
    err_r <= err_nxt; t_r <= t_nxt; y_r <= y_nxt; out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r; outv_nxt = outv_r;
    cnt_nxt = cnt_r; phase_nxt = phase_r; acc_nxt = acc_r;
    err_nxt = err_r; t_nxt = t_r; y_nxt = y_r; out_nxt = out_r;
    u_we = 1'b0; i_we = 1'b0;
    u_ra = {urow_r, kidx}; i_ra = {irow_r, kidx};
    u_wa = {urow_r, kidx}; i_wa = {irow_r, kidx};
    u_wd = val_r; i_wd = val_r;
    if (outv_r && out_tready) outv_nxt = 1'b0;
    case (state_r)
      sgdmf_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) state_nxt = sgdmf_pkg::ST_ACCESS;
      end
      sgdmf_pkg::ST_ACCESS: begin
        cnt_nxt = '0; acc_nxt = '0; phase_nxt = 1'b0;
        u_ra = {urow_r, fk}; i_ra = {irow_r, fk};
        case (kind_r)
          sgdmf_pkg::KIND_TRAIN: begin
            u_ra = {urow_r, {KW{1'b0}}}; i_ra = {irow_r, {KW{1'b0}}};
            state_nxt = sgdmf_pkg::ST_DOT;
          end
          sgdmf_pkg::KIND_WR_USER: begin
            u_we = fok; u_wa = {urow_r, fk};
            out_nxt = '0; state_nxt = sgdmf_pkg::ST_OUT;
          end
          sgdmf_pkg::KIND_WR_ITEM: begin
            i_we = fok; i_wa = {irow_r, fk};
            out_nxt = '0; state_nxt = sgdmf_pkg::ST_OUT;
          end
          sgdmf_pkg::KIND_RD_USER, sgdmf_pkg::KIND_RD_ITEM: state_nxt = sgdmf_pkg::ST_RDWAIT;
          default: begin
            out_nxt = '0; state_nxt = sgdmf_pkg::ST_OUT;
          end
        endcase
      end
      sgdmf_pkg::ST_RDWAIT: begin
        out_nxt[15:0] = '0;
        out_nxt[31:16] = !fok ? 16'd0 :
                         (kind_r == sgdmf_pkg::KIND_RD_USER) ? urd : ird;
        state_nxt = sgdmf_pkg::ST_OUT;
      end
      sgdmf_pkg::ST_DOT: begin
        // accumulate one product per cycle while the next element is read
        acc_nxt = acc_r + sgdmf_pkg::ACCW'(prod_uv);
        u_ra = {urow_r, KW'(cnt_r + 1'b1)}; i_ra = {irow_r, KW'(cnt_r + 1'b1)};
        if (last) state_nxt = sgdmf_pkg::ST_ERR;
        cnt_nxt = cnt_r + 1'b1;
      end
      sgdmf_pkg::ST_ERR: begin
        err_nxt = sgdmf_pkg::sat16(64'(ediff >>> 12));
        cnt_nxt = '0;
        state_nxt = sgdmf_pkg::ST_UPD_A;
      end
      sgdmf_pkg::ST_UPD_A: begin
        // issue reads of element k
        state_nxt = sgdmf_pkg::ST_UPD_B;
      end
      sgdmf_pkg::ST_UPD_B: begin
        t_nxt = (48'(prod_ex) <<< 4) - 48'(prod_ry);
        y_nxt = ysel;
        state_nxt = sgdmf_pkg::ST_UPD_C;
      end
      sgdmf_pkg::ST_UPD_C: begin
        // scale by step size and round half up
        t_nxt = dval;
        state_nxt = sgdmf_pkg::ST_UPD_D;
      end
      sgdmf_pkg::ST_UPD_D: begin
        u_wd = sgdmf_pkg::sat16(64'(t_r) + 64'(y_r));
        i_wd = u_wd;
        u_we = !phase_r; i_we = phase_r;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = sgdmf_pkg::ST_UPD_A;
        if (last) begin
          cnt_nxt = '0;
          if (phase_r) begin
            out_nxt = {16'd0, err_r};
            state_nxt = sgdmf_pkg::ST_OUT;
          end else phase_nxt = 1'b1;
        end
      end
      sgdmf_pkg::ST_OUT: begin
        outv_nxt = 1'b1;
        state_nxt = sgdmf_pkg::ST_IDLE;
      end
      default: state_nxt = sgdmf_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/sgdmf_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read data.
`default_nettype none
module sgdmf_ram #(
  parameter int AW = 14,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> verif/sgd_matrix_factor_update_top_tb.sv
// Self-checking testbench for the SGD matrix factorization update engine.
`timescale 1ns / 100ps
module sgd_matrix_factor_update_top_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 40;

  typedef struct packed {
    logic [15:0] err;
    logic [15:0] rd;
  } factor_result_t;

  typedef struct {
    logic [2:0]  kind;
    logic [9:0]  urow;
    logic [9:0]  irow;
    logic [3:0]  fidx;
    logic [15:0] value;
    bit          typed;
    logic [15:0] err;
    logic [15:0] rd;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  // Predictor state
  logic signed [15:0] user_tab [int];
  logic signed [15:0] item_tab [int];
  int                 user_keys [$];
  int                 item_keys [$];
  logic [15:0]        step_q = sgdmf_pkg::STEP_RESET;
  logic [15:0]        lam_q = sgdmf_pkg::REG_RESET;
  factor_result_t     pending [$];

  int errors = 0;
  int cycles = 0;
  int idle_mode = 0;
  int n_items = 0;
  int n_train = 0;
  int n_results = 0;

  int pool_u [4];
  int pool_i [4];

  sgd_matrix_factor_update_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check results and drive the receiver's stalls
  always @(posedge clk) begin
    factor_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending.pop_front();
        if (out_tdata[15:0] !== want.err) begin
          $display("%0t: error_out expected %h actual %h", $time, want.err, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[31:16] !== want.rd) begin
          $display("%0t: read_out expected %h actual %h", $time, want.rd, out_tdata[31:16]);
          errors++;
        end
      end
    end
    case (idle_mode)
      2: out_tready <= ($urandom_range(99) >= 71);
      3: out_tready <= ($urandom_range(99) >= 10);
      default: out_tready <= 1'b1;
    endcase
  end

  function automatic logic signed [15:0] clip16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  // One SGD element step: y + round(step * (16*e*x - lambda*y) / 2^32)
  function automatic logic signed [15:0] step_elem(logic signed [15:0] y,
                                                   logic signed [15:0] x,
                                                   logic signed [15:0] e);
    longint t, d;
    t = longint'(e) * longint'(x) * 16 - longint'(lam_q) * longint'(y);
    d = (longint'(step_q) * t + (64'sd1 <<< 31)) >>> 32;
    return clip16(longint'(y) + d);
  endfunction

  function automatic void note_written(ref logic signed [15:0] tab [int], ref int keys [$],
                                       input int key, input logic signed [15:0] v);
    if (!tab.exists(key)) keys = {keys, key};
    tab[key] = v;
  endfunction

  // Compute the result of one accepted request and advance the tables
  function automatic factor_result_t predict_update(logic [2:0] kind, logic [9:0] urow,
                                                    logic [9:0] irow, logic [3:0] fidx,
                                                    logic signed [15:0] value);
    factor_result_t r;
    logic signed [15:0] ur [sgdmf_pkg::K_FACTORS];
    logic signed [15:0] ir [sgdmf_pkg::K_FACTORS];
    logic signed [15:0] e;
    longint dot;
    int ukey, ikey;
    r = '0;
    ukey = {urow, fidx};
    ikey = {irow, fidx};
    case (kind)
      sgdmf_pkg::KIND_TRAIN: begin
        dot = 0;
        for (int j = 0; j < sgdmf_pkg::K_FACTORS; j++) begin
          ur[j] = user_tab[{urow, 4'(j)}];
          ir[j] = item_tab[{irow, 4'(j)}];
          dot += longint'(ur[j]) * longint'(ir[j]);
        end
        e = clip16((longint'(value) * 4096 - dot + 2048) >>> 12);
        for (int j = 0; j < sgdmf_pkg::K_FACTORS; j++) ur[j] = step_elem(ur[j], ir[j], e);
        for (int j = 0; j < sgdmf_pkg::K_FACTORS; j++) ir[j] = step_elem(ir[j], ur[j], e);
        for (int j = 0; j < sgdmf_pkg::K_FACTORS; j++) begin
          user_tab[{urow, 4'(j)}] = ur[j];
          item_tab[{irow, 4'(j)}] = ir[j];
        end
        r.err = e;
      end
      sgdmf_pkg::KIND_WR_USER: note_written(user_tab, user_keys, ukey, value);
      sgdmf_pkg::KIND_WR_ITEM: note_written(item_tab, item_keys, ikey, value);
      sgdmf_pkg::KIND_RD_USER: r.rd = user_tab[ukey];
      sgdmf_pkg::KIND_RD_ITEM: r.rd = item_tab[ikey];
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request, honoring the sender's idle pattern, and queue its result
  task automatic send_request(logic [2:0] kind, logic [9:0] urow, logic [9:0] irow,
                              logic [3:0] fidx, logic [15:0] value,
                              bit typed, factor_result_t typed_res);
    factor_result_t r;
    int gap;
    gap = (idle_mode == 1) ? 71 : (idle_mode == 3) ? 10 : 0;
    if (gap != 0 && $urandom_range(99) < gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {value, fidx, irow, urow};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_update(kind, urow, irow, fidx, value);
    if (kind == sgdmf_pkg::KIND_TRAIN) n_train++;
    n_items++;
    if (typed) r = typed_res;
    pending = {pending, r};
  endtask

  // Drain outstanding results, then write one register
  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == sgdmf_pkg::CFG_STEP) step_q = data;
    else lam_q = data;
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_request();
    int pick, key;
    factor_result_t none;
    none = '0;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_request(sgdmf_pkg::KIND_TRAIN, 10'(pool_u[$urandom_range(3)]),
                   10'(pool_i[$urandom_range(3)]), 4'($urandom), rand_value(), 0, none);
    end else if (pick < 55) begin
      send_request(sgdmf_pkg::KIND_WR_USER, 10'($urandom), 10'($urandom), 4'($urandom),
                   rand_value(), 0, none);
    end else if (pick < 65) begin
      send_request(sgdmf_pkg::KIND_WR_ITEM, 10'($urandom), 10'($urandom), 4'($urandom),
                   rand_value(), 0, none);
    end else if (pick < 77) begin
      key = user_keys[$urandom_range(user_keys.size() - 1)];
      send_request(sgdmf_pkg::KIND_RD_USER, 10'(key >> 4), 10'($urandom), 4'(key),
                   16'($urandom), 0, none);
    end else if (pick < 90) begin
      key = item_keys[$urandom_range(item_keys.size() - 1)];
      send_request(sgdmf_pkg::KIND_RD_ITEM, 10'($urandom), 10'(key >> 4), 4'(key),
                   16'($urandom), 0, none);
    end else begin
      // Unused kinds change nothing
      send_request(3'($urandom_range(7, 5)), 10'($urandom), 10'($urandom), 4'($urandom),
                   16'($urandom), 0, none);
    end
  endtask

  stim_row_t directed [14] = '{
    '{sgdmf_pkg::KIND_WR_USER, 10'd1023, 10'd0,    4'd15, 16'h7fff, 1, 16'h0, 16'h0},
    '{sgdmf_pkg::KIND_RD_USER, 10'd1023, 10'd0,    4'd15, 16'h0000, 1, 16'h0, 16'h7fff},
    '{sgdmf_pkg::KIND_WR_ITEM, 10'd0,    10'd0,    4'd0,  16'h8000, 1, 16'h0, 16'h0},
    '{sgdmf_pkg::KIND_RD_ITEM, 10'd0,    10'd0,    4'd0,  16'hffff, 1, 16'h0, 16'h8000},
    '{sgdmf_pkg::KIND_WR_USER, 10'd0,    10'd1023, 4'd0,  16'h0000, 1, 16'h0, 16'h0},
    '{sgdmf_pkg::KIND_RD_USER, 10'd0,    10'd1023, 4'd0,  16'h7fff, 1, 16'h0, 16'h0},
    '{sgdmf_pkg::KIND_WR_ITEM, 10'd1023, 10'd1023, 4'd15, 16'h1234, 1, 16'h0, 16'h0},
    '{sgdmf_pkg::KIND_RD_ITEM, 10'd0,    10'd1023, 4'd15, 16'h0000, 0, 16'h0, 16'h0},
    '{sgdmf_pkg::KIND_WR_USER, 10'd1023, 10'd1023, 4'd15, 16'h8000, 0, 16'h0, 16'h0},
    '{sgdmf_pkg::KIND_RD_USER, 10'd1023, 10'd1023, 4'd15, 16'h8000, 0, 16'h0, 16'h0},
    '{3'd5,                    10'd1023, 10'd1023, 4'd15, 16'hffff, 1, 16'h0, 16'h0},
    '{3'd6,                    10'd0,    10'd0,    4'd0,  16'h0000, 1, 16'h0, 16'h0},
    '{3'd7,                    10'd1023, 10'd1023, 4'd15, 16'h7fff, 1, 16'h0, 16'h0},
    '{sgdmf_pkg::KIND_RD_ITEM, 10'd1023, 10'd0,    4'd0,  16'h0000, 1, 16'h0, 16'h8000}
  };

  logic [15:0] steps [5] = '{sgdmf_pkg::STEP_RESET, 16'd0, 16'hffff, 16'd0, 16'hffff};
  logic [15:0] lams  [5] = '{sgdmf_pkg::REG_RESET, 16'd0, 16'hffff, 16'hffff, 16'd0};

  initial begin
    factor_result_t typed_res;
    pool_u = '{0, 1023, 0, 0};
    pool_i = '{0, 1023, 0, 0};
    pool_u[2] = $urandom_range(1, 1022);
    pool_u[3] = $urandom_range(1, 1022);
    pool_i[2] = $urandom_range(1, 1022);
    pool_i[3] = $urandom_range(1, 1022);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed[n]) begin
      typed_res.err = directed[n].err;
      typed_res.rd  = directed[n].rd;
      send_request(directed[n].kind, directed[n].urow, directed[n].irow, directed[n].fidx,
                   directed[n].value, directed[n].typed, typed_res);
    end

    // Load every element of the training pool rows
    typed_res = '0;
    for (int p = 0; p < 4; p++)
      for (int j = 0; j < sgdmf_pkg::K_FACTORS; j++) begin
        send_request(sgdmf_pkg::KIND_WR_USER, 10'(pool_u[p]), 10'($urandom), 4'(j),
                     rand_value(), 0, typed_res);
        send_request(sgdmf_pkg::KIND_WR_ITEM, 10'($urandom), 10'(pool_i[p]), 4'(j),
                     rand_value(), 0, typed_res);
      end

    // Random phases over register settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        write_reg(sgdmf_pkg::CFG_STEP, 16'($urandom));
        write_reg(sgdmf_pkg::CFG_REG, 16'($urandom));
      end else begin
        write_reg(sgdmf_pkg::CFG_STEP, steps[ph % 5]);
        write_reg(sgdmf_pkg::CFG_REG, lams[ph % 5]);
      end
      idle_mode = ph % 4;
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d requests (%0d training updates), %0d results checked,",
             n_items, n_train, n_results);
    $display("over five register settings and four idle patterns.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
